/* src/sha256_register_accelerator_top_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef SHA256_REGISTER_ACCELERATOR_TOP_DEFINES_SVH
`define SHA256_REGISTER_ACCELERATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/sha256ra_pkg.sv */
`default_nettype none

package sha256ra_pkg;

  localparam int unsigned NumHash = 8;
  localparam int unsigned NumMsg = 16;
  localparam int unsigned NumRounds = 64;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic clear;
    logic load_iv;
    logic start;
    logic step;
    logic finish;
  } ctl_t;

  localparam logic OpRead = 1'b0;
  localparam logic OpWrite = 1'b1;

  localparam logic [25:0] AddrCtrl = 26'h000;
  localparam logic [25:0] AddrId = 26'h008;
  localparam logic [25:0] AddrMsgLo = 26'h010;
  localparam logic [25:0] AddrMsgHi = 26'h04C;
  localparam logic [25:0] AddrHashLo = 26'h060;
  localparam logic [25:0] AddrHashHi = 26'h07C;

  localparam word_t IdValue = 32'h0000_0500;
  localparam int unsigned CtlClearBit = 4;
  localparam word_t CtlIvMask = 32'h0000_000E;
  localparam word_t CtlIvCode = 32'h0000_000A;
  localparam word_t CtlRunMask = 32'h0000_000A;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t init_hash(input logic [2:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t r;
    unique case (idx)
      6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
      6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
      6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
      6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/sha256ra_sched.sv */
`default_nettype none

module sha256ra_sched (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_en,
  input  wire logic [3:0]          wr_idx,
  input  wire sha256ra_pkg::word_t wr_data,
  input  wire sha256ra_pkg::ctl_t  ctl,
  output sha256ra_pkg::word_t      w
);

  sha256ra_pkg::word_t msg [sha256ra_pkg::NumMsg];
  sha256ra_pkg::word_t win [sha256ra_pkg::NumMsg];
  sha256ra_pkg::word_t w_new;

  assign w = win[0];
  assign w_new = sha256ra_pkg::small_sigma1(win[14]) + win[9]
               + sha256ra_pkg::small_sigma0(win[1]) + win[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sha256ra_pkg::NumMsg; i++) begin
        msg[i] <= '0;
      end
    end else if (wr_en) begin
      msg[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < sha256ra_pkg::NumMsg; i++) begin
        win[i] <= msg[i];
      end
    end else if (ctl.step) begin
      for (int i = 0; i < sha256ra_pkg::NumMsg - 1; i++) begin
        win[i] <= win[i + 1];
      end
      win[sha256ra_pkg::NumMsg - 1] <= w_new;
    end
  end

endmodule

`default_nettype wire

/* src/sha256ra_core.sv */
`default_nettype none

module sha256ra_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sha256ra_pkg::ctl_t  ctl,
  input  wire logic [5:0]          rnd,
  input  wire sha256ra_pkg::word_t w,
  input  wire logic [2:0]          rd_idx,
  output sha256ra_pkg::word_t      rd_data
);

  sha256ra_pkg::word_t hash [sha256ra_pkg::NumHash];
  sha256ra_pkg::word_t v [sha256ra_pkg::NumHash];
  sha256ra_pkg::word_t ch;
  sha256ra_pkg::word_t maj;
  sha256ra_pkg::word_t t1;
  sha256ra_pkg::word_t t2;

  assign rd_data = hash[rd_idx];

  assign ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1 = v[7] + sha256ra_pkg::big_sigma1(v[4]) + ch + sha256ra_pkg::round_k(rnd) + w;
  assign t2 = sha256ra_pkg::big_sigma0(v[0]) + maj;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sha256ra_pkg::NumHash; i++) begin
        hash[i] <= '0;
      end
    end else if (ctl.clear) begin
      for (int i = 0; i < sha256ra_pkg::NumHash; i++) begin
        hash[i] <= '0;
      end
    end else if (ctl.load_iv) begin
      for (int i = 0; i < sha256ra_pkg::NumHash; i++) begin
        hash[i] <= sha256ra_pkg::init_hash(3'(i));
      end
    end else if (ctl.finish) begin
      for (int i = 0; i < sha256ra_pkg::NumHash; i++) begin
        hash[i] <= hash[i] + v[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      for (int i = 0; i < sha256ra_pkg::NumHash; i++) begin
        v[i] <= ctl.load_iv ? sha256ra_pkg::init_hash(3'(i)) : hash[i];
      end
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

`default_nettype wire

/* src/sha256_register_accelerator_top.sv */
// Channel   Handshake                Payload
// input     in_valid / in_ready      opcode, address, write_data
// output    out_valid / out_ready    read_data, access_error
//
// The result of a register access is registered and presented in the next cycle.
// A write to control that starts a compression keeps in_ready low while the 64
// rounds run in the shared round unit and during the final addition; the next
// item can be accepted only once the sequencer is back in idle.
// Reset is synchronous and clears the hash state, the message words and the sequencer.
// A stalled output holds its result, and no new item is taken until it is gone.
`default_nettype none

module sha256_register_accelerator_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [25:0] address,
  input  wire logic [31:0] write_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_data,
  output logic             access_error
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRound = 2'd1;
  localparam logic [1:0] StFinal = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [5:0] rnd;
  logic [5:0] rnd_next;

  logic accept;
  logic is_write;
  logic hit_ctrl;
  logic hit_id;
  logic hit_msg;
  logic hit_hash;
  logic [25:0] msg_off;
  logic msg_wr;
  logic [31:0] rd_next;
  logic err_next;
  sha256ra_pkg::ctl_t ctl;
  sha256ra_pkg::word_t hash_rd;
  sha256ra_pkg::word_t w;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == StIdle) && (!out_valid || out_ready);
  assign is_write = (opcode == sha256ra_pkg::OpWrite);

  assign hit_ctrl = (address == sha256ra_pkg::AddrCtrl);
  assign hit_id = (address == sha256ra_pkg::AddrId);
  assign hit_msg = (address >= sha256ra_pkg::AddrMsgLo) && (address <= sha256ra_pkg::AddrMsgHi)
                 && (address[1:0] == 2'b00);
  assign hit_hash = (address >= sha256ra_pkg::AddrHashLo) && (address <= sha256ra_pkg::AddrHashHi)
                  && (address[1:0] == 2'b00);
  assign msg_off = address - sha256ra_pkg::AddrMsgLo;
  assign msg_wr = accept && is_write && hit_msg;

  always_comb begin
    ctl = '0;
    if (accept && is_write && hit_ctrl && !write_data[sha256ra_pkg::CtlClearBit]) begin
      ctl.load_iv = ((write_data & sha256ra_pkg::CtlIvMask) == sha256ra_pkg::CtlIvCode);
      ctl.start = ((write_data & sha256ra_pkg::CtlRunMask) == sha256ra_pkg::CtlRunMask);
    end
    ctl.clear = accept && is_write && hit_ctrl && write_data[sha256ra_pkg::CtlClearBit];
    ctl.step = (state == StRound);
    ctl.finish = (state == StFinal);
  end

  always_comb begin
    rd_next = '0;
    err_next = 1'b0;
    if (is_write) begin
      err_next = !(hit_ctrl || hit_id || hit_msg);
    end else if (hit_ctrl) begin
      rd_next = '0;
    end else if (hit_id) begin
      rd_next = sha256ra_pkg::IdValue;
    end else if (hit_hash) begin
      rd_next = hash_rd;
    end else begin
      err_next = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    rnd_next = rnd;
    unique case (state)
      StIdle: begin
        if (ctl.start) begin
          state_next = StRound;
          rnd_next = '0;
        end
      end
      StRound: begin
        rnd_next = rnd + 6'd1;
        if (rnd == 6'(sha256ra_pkg::NumRounds - 1)) begin
          state_next = StFinal;
        end
      end
      StFinal: begin
        state_next = StIdle;
      end
      default: begin
        state_next = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      rnd <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rnd <= rnd_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= rd_next;
      access_error <= err_next;
    end
  end

  sha256ra_sched u_sched (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (msg_wr),
    .wr_idx  (msg_off[5:2]),
    .wr_data (write_data),
    .ctl     (ctl),
    .w       (w)
  );

  sha256ra_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rnd     (rnd),
    .w       (w),
    .rd_idx  (address[4:2]),
    .rd_data (hash_rd)
  );

endmodule

`default_nettype wire

/* src/sha256ra_checker.sv */
`default_nettype none

`include "sha256_register_accelerator_top_defines.svh"

module sha256ra_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        opcode,
  input wire logic [25:0] address,
  input wire logic [31:0] write_data,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] read_data,
  input wire logic        access_error
);

  logic accept;
  logic run_cmd;

  assign accept = in_valid && in_ready;
  assign run_cmd = accept && opcode && (address == 26'h0) && !write_data[4]
                 && write_data[3] && write_data[1];

  `SRA_ASSERT_NEXT(a_result_follows, accept, out_valid, "Accepted item gave no result.")
  `SRA_ASSERT_NEXT(a_write_reads_zero, accept && opcode, read_data == 32'h0, "Write result not zero.")
  `SRA_ASSERT_NEXT(a_id_value, accept && !opcode && (address == 26'h8), (read_data == 32'h500) && !access_error, "Wrong identification value.")
  `SRA_ASSERT_NEXT(a_busy_after_run, run_cmd, !in_ready, "Input taken while compression runs.")
  `SRA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(access_error), "Stalled result changed.")

endmodule

bind sha256_register_accelerator_top sha256ra_checker u_checker (.*);

`default_nettype wire
